// ===== src/kdpc_pkg.sv =====
// Shared types and constants for the key debounce press counter.
package kdpc_pkg;

   // Debounce states
   localparam logic [1:0] ST_UP          = 2'd0;
   localparam logic [1:0] ST_DOWN_BOUNCE = 2'd1;
   localparam logic [1:0] ST_DOWN        = 2'd2;
   localparam logic [1:0] ST_UP_BOUNCE   = 2'd3;

   // Request opcodes
   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_READ_COUNT = 2'd1;
   localparam logic [1:0] OP_READ_STATE = 2'd2;

   // Register indexes (byte address bit 2)
   localparam logic REG_TICK_PERIOD = 1'b0;
   localparam logic REG_BOUNCE_TIME = 1'b1;

   localparam logic [7:0] COUNT_LIMIT       = 8'd250;
   localparam logic [7:0] TICK_PERIOD_RESET = 8'd10;
   localparam logic [7:0] BOUNCE_TIME_RESET = 8'd20;

   typedef struct packed {
      logic [1:0] op;
      logic       pin_pressed;
      logic       clear_count;
   } req_word_type;

   typedef struct packed {
      logic [1:0] btn_state;
      logic [7:0] press_count;
      logic       changed;
   } rsp_word_type;

endpackage

// ===== src/kdpc_stream_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
interface kdpc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       pin_pressed;
   logic       clear_count;

   modport source (output valid, output op, output pin_pressed, output clear_count,
                   input ready);
   modport sink   (input valid, input op, input pin_pressed, input clear_count,
                   output ready);
endinterface

interface kdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] btn_state;
   logic [7:0] press_count;
   logic       changed;

   modport source (output valid, output btn_state, output press_count, output changed,
                   input ready);
   modport sink   (input valid, input btn_state, input press_count, input changed,
                   output ready);
endinterface

// ===== src/key_debounce_press_counter.sv =====
// Push-button debouncer with saturating release counter, top level.
//
//  channel   dir  handshake              word
//  req_ch    in   valid/ready            op, pin_pressed, clear_count
//  rsp_ch    out  valid/ready            btn_state, press_count, changed
//  csr       in   APB (psel/penable)     tick_period_ms @0x0, bounce_time_ms @0x4
//
// One word per cycle sustained while the response side keeps ready high;
// words pass through the input register, then the result register. The debounce
// update runs in the single logic stage between the two registers.
// Reset is synchronous: key up, timer/count/flag zero, registers 10 and 20.
// A stalled response holds the result register; the input register keeps
// taking words while the result register is free or being drained.
module key_debounce_press_counter
   import kdpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   kdpc_req_if.sink    req_ch,
   kdpc_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Config registers
   logic [7:0] tick_period_ff, bounce_time_ff;

   // Input stage
   logic         s1_valid_ff;
   req_word_type s1_word_ff;

   // Result stage
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   // Debounce state
   logic [1:0] state_ff, state_in;
   logic [8:0] elapsed_ff, elapsed_in;
   logic [7:0] count_ff, count_in;
   logic       flag_ff, flag_in;
   logic       flag_out;

   logic       rsp_load;
   logic       s1_load;
   logic [8:0] elapsed_sum;
   logic       settled;
   logic       csr_write;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == REG_BOUNCE_TIME) begin
         prdata = {24'd0, bounce_time_ff};
      end else begin
         prdata = {24'd0, tick_period_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= TICK_PERIOD_RESET;
         bounce_time_ff <= BOUNCE_TIME_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_TICK_PERIOD) begin
            tick_period_ff <= pwdata[7:0];
         end else begin
            bounce_time_ff <= pwdata[7:0];
         end
      end
   end

   // ---------------- pipeline control ----------------
   // Result register loads when empty or being drained this cycle.
   assign rsp_load     = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign s1_load      = !s1_valid_ff || rsp_load;
   assign req_ch.ready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_ch.valid) begin
         s1_word_ff.op          <= req_ch.op;
         s1_word_ff.pin_pressed <= req_ch.pin_pressed;
         s1_word_ff.clear_count <= req_ch.clear_count;
      end
   end

   // ---------------- debounce update ----------------
   // Bounce timer: 9-bit sum never wraps for 8-bit operands and stops
   // growing only past the point where it is compared.
   assign elapsed_sum = elapsed_ff + {1'b0, tick_period_ff};
   assign settled     = elapsed_sum >= {1'b0, bounce_time_ff};

   always_comb begin
      state_in   = state_ff;
      elapsed_in = elapsed_ff;
      count_in   = count_ff;
      flag_in    = flag_ff;
      flag_out   = flag_ff;
      case (s1_word_ff.op)
         OP_TICK: begin
            unique case (state_ff)
               ST_UP: begin
                  if (s1_word_ff.pin_pressed) begin
                     elapsed_in = 9'd0;
                     state_in   = ST_DOWN_BOUNCE;
                  end
               end
               ST_DOWN_BOUNCE: begin
                  elapsed_in = elapsed_sum;
                  if (settled) begin
                     if (s1_word_ff.pin_pressed) begin
                        flag_in  = 1'b1;
                        state_in = ST_DOWN;
                     end else begin
                        state_in = ST_UP;
                     end
                  end
               end
               ST_DOWN: begin
                  if (!s1_word_ff.pin_pressed) begin
                     elapsed_in = 9'd0;
                     state_in   = ST_UP_BOUNCE;
                  end
               end
               default: begin
                  // up-bounce: confirmed release bumps the count
                  elapsed_in = elapsed_sum;
                  if (settled) begin
                     if (!s1_word_ff.pin_pressed) begin
                        flag_in  = 1'b1;
                        state_in = ST_UP;
                        if (count_ff < COUNT_LIMIT) begin
                           count_in = count_ff + 8'd1;
                        end
                     end else begin
                        state_in = ST_DOWN;
                     end
                  end
               end
            endcase
            flag_out = flag_in;
         end
         OP_READ_COUNT: begin
            if (s1_word_ff.clear_count) begin
               count_in = 8'd0;
            end
         end
         OP_READ_STATE: begin
            // report the flag as it was, then clear it
            flag_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_UP;
         elapsed_ff <= 9'd0;
         count_ff   <= 8'd0;
         flag_ff    <= 1'b0;
      end else if (rsp_load) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         count_ff   <= count_in;
         flag_ff    <= flag_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff.btn_state   <= state_in;
         rsp_word_ff.press_count <= count_in;
         rsp_word_ff.changed     <= flag_out;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.btn_state   = rsp_word_ff.btn_state;
   assign rsp_ch.press_count = rsp_word_ff.press_count;
   assign rsp_ch.changed     = rsp_word_ff.changed;

endmodule

// ===== dv/kdpc_test_pkg.sv =====
// Debounce predictor and result scoreboard for the key debounce test.
package kdpc_test_pkg;
   import kdpc_pkg::*;

   // op 3 is legal on the wire; it reads back state without side effects
   localparam logic [1:0] OP_PASSIVE = 2'd3;

   class debounce_checker;
      logic [7:0]   tick_period;
      logic [7:0]   bounce_time;
      logic [1:0]   btn_state;
      logic [8:0]   elapsed;
      logic [7:0]   presses;
      logic         change_flag;
      rsp_word_type due_words[$];
      int           mismatch_count;

      function new();
         tick_period    = TICK_PERIOD_RESET;
         bounce_time    = BOUNCE_TIME_RESET;
         btn_state      = ST_UP;
         elapsed        = '0;
         presses        = '0;
         change_flag    = 1'b0;
         mismatch_count = 0;
      endfunction

      function void set_register(logic idx, logic [7:0] value);
         if (idx == REG_TICK_PERIOD) begin
            tick_period = value;
         end else begin
            bounce_time = value;
         end
      endfunction

      // one sample tick of the four-state debouncer
      function void step_key(logic pressed);
         case (btn_state)
            ST_UP: begin
               if (pressed) begin
                  elapsed   = '0;
                  btn_state = ST_DOWN_BOUNCE;
               end
            end
            ST_DOWN_BOUNCE: begin
               elapsed = elapsed + {1'b0, tick_period};
               if (elapsed >= {1'b0, bounce_time}) begin
                  if (pressed) begin
                     change_flag = 1'b1;
                     btn_state   = ST_DOWN;
                  end else begin
                     btn_state = ST_UP;
                  end
               end
            end
            ST_DOWN: begin
               if (!pressed) begin
                  elapsed   = '0;
                  btn_state = ST_UP_BOUNCE;
               end
            end
            default: begin
               elapsed = elapsed + {1'b0, tick_period};
               if (elapsed >= {1'b0, bounce_time}) begin
                  if (!pressed) begin
                     change_flag = 1'b1;
                     btn_state   = ST_UP;
                     if (presses < COUNT_LIMIT) presses = presses + 8'd1;
                  end else begin
                     btn_state = ST_DOWN;
                  end
               end
            end
         endcase
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         logic         flag_out;
         case (w.op)
            OP_TICK: begin
               step_key(w.pin_pressed);
               flag_out = change_flag;
            end
            OP_READ_COUNT: begin
               if (w.clear_count) presses = '0;
               flag_out = change_flag;
            end
            OP_READ_STATE: begin
               flag_out    = change_flag;
               change_flag = 1'b0;
            end
            default: flag_out = change_flag;
         endcase
         r.btn_state   = btn_state;
         r.press_count = presses;
         r.changed     = flag_out;
         due_words.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      task check_word(rsp_word_type got);
         rsp_word_type want;
         if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word state=%0d count=%0d changed=%0d",
                                      got.btn_state, got.press_count, got.changed));
         end else begin
            want = due_words.pop_front();
            if (got.btn_state !== want.btn_state)
               report_mismatch($sformatf("btn_state %0d, want %0d",
                                         got.btn_state, want.btn_state));
            if (got.press_count !== want.press_count)
               report_mismatch($sformatf("press_count %0d, want %0d",
                                         got.press_count, want.press_count));
            if (got.changed !== want.changed)
               report_mismatch($sformatf("changed %0d, want %0d",
                                         got.changed, want.changed));
         end
      endtask
   endclass

endpackage

// ===== dv/key_debounce_press_counter_test.sv =====
// Self-checking testbench for the key debounce press counter.
module key_debounce_press_counter_test;
   import kdpc_pkg::*;
   import kdpc_test_pkg::*;

   // receiver hold-off length used to back the block up into its input
   localparam int HOLD_OFF_CYCLES = 64;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   kdpc_req_if req ();
   kdpc_rsp_if rsp ();

   debounce_checker sb;

   int items_sent;          // request words accepted so far
   int sender_idle_pct;     // chance per cycle that the request side idles
   int receiver_idle_pct;   // chance per cycle that the response side stalls
   bit hold_off_req;        // main flow asks the receiver for a long stall

   key_debounce_press_counter dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req),
      .rsp_ch  (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: ends the run as NOT OK if the test hangs.
   initial begin
      #2000000;
      $display("key_debounce_press_counter_test NOT OK");
      $finish;
   end

   // Response side. Ready changes on the falling edge only. A hold-off
   // request parks ready low for the hold-off length while the main
   // flow keeps offering words, so the block fills and drops req ready.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Every accepted response word is checked against the oldest prediction.
   always @(posedge clock) begin : response_monitor
      rsp_word_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.btn_state   = rsp.btn_state;
         got.press_count = rsp.press_count;
         got.changed     = rsp.changed;
         sb.check_word(got);
      end
   end

   // Offer one request word; returns on the falling edge after acceptance.
   // Valid stays high into the next call unless that call chooses to idle.
   task send_word(input req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.op          <= w.op;
      req.pin_pressed <= w.pin_pressed;
      req.clear_count <= w.clear_count;
      do @(posedge clock); while (!req.ready);
      sb.note_request(w);
      items_sent++;
      @(negedge clock);
   endtask

   task send_fields(input logic [1:0] op, input logic pin, input logic clr);
      req_word_type w;
      w.op          = op;
      w.pin_pressed = pin;
      w.clear_count = clr;
      send_word(w);
   endtask

   // A random read: count (maybe clearing), state, or the passive op.
   // Fields the op ignores carry random bits.
   task send_read(input bit allow_clear);
      int pick;
      pick = $urandom_range(2);
      if (pick == 0)
         send_fields(OP_READ_COUNT, 1'($urandom()),
                     allow_clear && ($urandom_range(99) < 20));
      else if (pick == 1)
         send_fields(OP_READ_STATE, 1'($urandom()), 1'($urandom()));
      else
         send_fields(OP_PASSIVE, 1'($urandom()), 1'($urandom()));
   endtask

   // One APB transfer: setup cycle, then access cycle until pready.
   // Leaves psel high; the caller closes the burst, so no signal gets two
   // assignments on the same falling edge.
   task apb_access(input bit is_write, input logic idx, input logic [7:0] value,
                   output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      if (is_write) sb.set_register(idx, value);
      @(negedge clock);
   endtask

   // Write both registers and read each one back.
   task configure(input logic [7:0] tick_ms, input logic [7:0] bounce_ms);
      logic [31:0] readback;
      apb_access(1'b1, REG_TICK_PERIOD, tick_ms, readback);
      apb_access(1'b0, REG_TICK_PERIOD, 8'd0, readback);
      if (readback[7:0] !== tick_ms)
         sb.report_mismatch($sformatf("tick period reads %0d, want %0d",
                                      readback[7:0], tick_ms));
      apb_access(1'b1, REG_BOUNCE_TIME, bounce_ms, readback);
      apb_access(1'b0, REG_BOUNCE_TIME, 8'd0, readback);
      if (readback[7:0] !== bounce_ms)
         sb.report_mismatch($sformatf("bounce time reads %0d, want %0d",
                                      readback[7:0], bounce_ms));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Drop valid, drain every outstanding response, then let the two-stage
   // pipe go quiet before touching registers.
   task settle();
      req.valid <= 1'b0;
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Random traffic built from key runs: the pin holds one level for a
   // stretch sized around the debounce window (some short enough to fail,
   // some long enough to confirm), with glitches, reads mixed in, and
   // occasional bursts of fully random words.
   // In fill mode the runs are exactly as long as a confirm needs and the
   // count is never cleared, so the press count climbs to its ceiling.
   task run_phase(input int n_items, input bit allow_clear, input bit fill_count);
      int start;
      int full_mark;
      int need;
      int run_len;
      int hold_offs;
      bit level;
      bit done;
      start     = items_sent;
      full_mark = -1;
      hold_offs = 0;
      level     = 1'b0;
      done      = 1'b0;
      while (!done) begin
         // ticks to confirm: one to enter the bounce state, then enough to
         // reach the bounce time (at least one)
         need = 1 + ((sb.bounce_time == 0) ? 1 :
                     (int'(sb.bounce_time) + int'(sb.tick_period) - 1) /
                     int'(sb.tick_period));
         if (!fill_count && $urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 4))
               send_fields(2'($urandom_range(3)), 1'($urandom()),
                           allow_clear && 1'($urandom()));
         end else begin
            run_len = fill_count ? need : $urandom_range(1, need + 2);
            repeat (run_len) begin
               if ($urandom_range(99) < (fill_count ? 5 : 15)) send_read(allow_clear);
               send_fields(OP_TICK,
                           (!fill_count && $urandom_range(99) < 8) ? !level : level,
                           1'($urandom()));
            end
            level = !level;
         end
         if (fill_count) begin
            if (full_mark < 0 && sb.presses == COUNT_LIMIT) full_mark = items_sent;
            if (hold_offs < 2 && items_sent - start >= 300 * (hold_offs + 1)) begin
               hold_off_req = 1'b1;
               hold_offs++;
            end
            done = (full_mark >= 0 && items_sent - full_mark >= 60) ||
                   (items_sent - start >= 1600);
         end else begin
            done = (items_sent - start >= n_items);
         end
      end
   endtask

   initial begin
      sb                = new();
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req.valid         = 1'b0;
      req.op            = OP_TICK;
      req.pin_pressed   = 1'b0;
      req.clear_count   = 1'b0;
      items_sent        = 0;
      hold_off_req      = 1'b0;
      sender_idle_pct   = 34;
      receiver_idle_pct = 66;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed, reset register values (tick 10, bounce 20) ---
      // reads straight out of reset, ignored fields set high
      send_fields(OP_READ_STATE, 1'b1, 1'b1);
      send_fields(OP_READ_COUNT, 1'b1, 1'b0);
      send_fields(OP_PASSIVE, 1'b1, 1'b1);
      send_fields(OP_TICK, 1'b0, 1'b1);         // released while up: no change
      // press that bounces back: key returns up without flagging a change
      send_fields(OP_TICK, 1'b1, 1'b0);
      send_fields(OP_TICK, 1'b0, 1'b0);
      send_fields(OP_TICK, 1'b0, 1'b0);
      // clean press: confirmed on the tick that reaches the bounce time
      send_fields(OP_TICK, 1'b1, 1'b0);
      send_fields(OP_TICK, 1'b1, 1'b0);
      send_fields(OP_TICK, 1'b1, 1'b1);
      send_fields(OP_READ_STATE, 1'b0, 1'b0);   // flag seen set, then cleared
      send_fields(OP_READ_STATE, 1'b0, 1'b1);
      // release that bounces back to down
      send_fields(OP_TICK, 1'b0, 1'b0);
      send_fields(OP_TICK, 1'b1, 1'b0);
      send_fields(OP_TICK, 1'b1, 1'b0);
      // clean release: one count
      send_fields(OP_TICK, 1'b0, 1'b0);
      send_fields(OP_TICK, 1'b0, 1'b0);
      send_fields(OP_TICK, 1'b0, 1'b0);
      send_fields(OP_READ_COUNT, 1'b0, 1'b0);
      send_fields(OP_READ_COUNT, 1'b0, 1'b1);   // clear then read

      // zero tick period: the bounce state never times out
      settle();
      configure(8'd0, 8'd5);
      send_fields(OP_TICK, 1'b1, 1'b0);
      send_fields(OP_TICK, 1'b1, 1'b0);
      // zero bounce time lets the stuck bounce settle on its next tick
      settle();
      configure(8'd0, 8'd0);
      send_fields(OP_TICK, 1'b1, 1'b0);
      // both registers at the top: one tick reaches the bounce time exactly
      settle();
      configure(8'd255, 8'd255);
      send_fields(OP_TICK, 1'b0, 1'b0);
      send_fields(OP_TICK, 1'b0, 1'b0);

      // --- random phases; sender idles less than receiver first ---
      settle();
      configure(8'd7, 8'd30);
      run_phase(200, 1'b1, 1'b0);
      settle();
      configure(8'd1, 8'd4);
      run_phase(200, 1'b1, 1'b0);

      // sender idles more than receiver
      sender_idle_pct   = 66;
      receiver_idle_pct = 34;
      settle();
      configure(8'd255, 8'd255);
      run_phase(200, 1'b1, 1'b0);
      settle();
      configure(8'd3, 8'd17);
      run_phase(200, 1'b1, 1'b0);

      // full rate both ways; drive the count to saturation, with two long
      // receiver stalls along the way
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      settle();
      configure(8'd1, 8'd0);
      run_phase(0, 1'b0, 1'b1);

      settle();
      repeat (4) @(posedge clock);
      if (sb.due_words.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.due_words.size()));
      if (sb.mismatch_count == 0) begin
         $display("key_debounce_press_counter_test OK");
      end else begin
         $display("key_debounce_press_counter_test NOT OK");
      end
      $finish;
   end

endmodule
